/* rtl/xlsu_pkg.sv */
package xlsu_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned OpWidth    = 4;
   localparam int unsigned SizeWidth  = 2;
   localparam int unsigned CountWidth = 5;
   localparam int unsigned ReqBits    = OpWidth + 2 * DataWidth + 2 * SizeWidth;
   localparam int unsigned RspFields  = DataWidth + 5;
   localparam int unsigned RspBits    = ((RspFields + 7) / 8) * 8;

   localparam logic [OpWidth-1:0] OP_TEST = 4'd0;
   localparam logic [OpWidth-1:0] OP_AND  = 4'd1;
   localparam logic [OpWidth-1:0] OP_XOR  = 4'd2;
   localparam logic [OpWidth-1:0] OP_OR   = 4'd3;
   localparam logic [OpWidth-1:0] OP_SAR  = 4'd4;
   localparam logic [OpWidth-1:0] OP_SHL  = 4'd5;
   localparam logic [OpWidth-1:0] OP_SHR  = 4'd6;
   localparam logic [OpWidth-1:0] OP_NOT  = 4'd7;
   localparam logic [OpWidth-1:0] OP_ROL  = 4'd8;

   localparam logic [SizeWidth-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SizeWidth-1:0] SIZE_WORD = 2'd1;

   typedef struct packed {
      logic [SizeWidth-1:0] source_width;
      logic [SizeWidth-1:0] operand_width;
      logic [DataWidth-1:0] src_value;
      logic [DataWidth-1:0] dest_value;
      logic [OpWidth-1:0]   op;
   } req_type;

   typedef struct packed {
      logic overflow;
      logic carry;
      logic sign;
      logic zero;
   } flags_type;

   typedef struct packed {
      logic                 write_back;
      logic [DataWidth-1:0] result;
   } res_type;

endpackage

/* rtl/xlsu_exec.sv */
module xlsu_exec (
   input  xlsu_pkg::req_type   req,
   input  xlsu_pkg::flags_type flags_cur,
   output xlsu_pkg::res_type   res,
   output xlsu_pkg::flags_type flags_nxt
);

   logic [xlsu_pkg::DataWidth-1:0]   mask;
   logic [xlsu_pkg::DataWidth-1:0]   src_mask;
   logic [xlsu_pkg::DataWidth-1:0]   d;
   logic [xlsu_pkg::DataWidth-1:0]   s;
   logic [xlsu_pkg::DataWidth-1:0]   s_ext;
   logic [xlsu_pkg::DataWidth-1:0]   d_ext;
   logic [xlsu_pkg::DataWidth-1:0]   pattern;
   logic [2*xlsu_pkg::DataWidth-1:0] rot_wide;
   logic [xlsu_pkg::DataWidth-1:0]   r;
   logic [xlsu_pkg::CountWidth-1:0]  cnt;
   logic [xlsu_pkg::CountWidth-1:0]  rot_n;
   logic                             msb;
   logic                             src_msb;
   logic                             logic_op;
   logic                             shift_op;
   logic                             wb;

   assign cnt = req.src_value[xlsu_pkg::CountWidth-1:0];

   always_comb begin
      case (req.operand_width)
         xlsu_pkg::SIZE_BYTE: begin
            mask    = 32'h0000_00ff;
            d_ext   = {{24{req.dest_value[7]}}, req.dest_value[7:0]};
            pattern = {4{req.dest_value[7:0]}};
            rot_n   = {2'b00, cnt[2:0]};
         end
         xlsu_pkg::SIZE_WORD: begin
            mask    = 32'h0000_ffff;
            d_ext   = {{16{req.dest_value[15]}}, req.dest_value[15:0]};
            pattern = {2{req.dest_value[15:0]}};
            rot_n   = {1'b0, cnt[3:0]};
         end
         default: begin
            mask    = 32'hffff_ffff;
            d_ext   = req.dest_value;
            pattern = req.dest_value;
            rot_n   = cnt;
         end
      endcase
   end

   always_comb begin
      case (req.source_width)
         xlsu_pkg::SIZE_BYTE: begin
            src_mask = 32'h0000_00ff;
            src_msb  = req.src_value[7];
         end
         xlsu_pkg::SIZE_WORD: begin
            src_mask = 32'h0000_ffff;
            src_msb  = req.src_value[15];
         end
         default: begin
            src_mask = 32'hffff_ffff;
            src_msb  = req.src_value[31];
         end
      endcase
   end

   assign d        = req.dest_value & mask;
   assign s        = req.src_value & mask;
   assign s_ext    = (req.src_value & src_mask) | (src_msb ? ~src_mask : '0);
   assign rot_wide = {pattern, pattern} << rot_n;

   always_comb begin
      r        = '0;
      wb       = 1'b0;
      logic_op = 1'b0;
      shift_op = 1'b0;
      case (req.op)
         xlsu_pkg::OP_TEST: begin
            r        = d & s;
            logic_op = 1'b1;
         end
         xlsu_pkg::OP_AND: begin
            r        = d & s_ext;
            wb       = 1'b1;
            logic_op = 1'b1;
         end
         xlsu_pkg::OP_XOR: begin
            r        = d ^ s;
            wb       = 1'b1;
            logic_op = 1'b1;
         end
         xlsu_pkg::OP_OR: begin
            r        = d | s;
            wb       = 1'b1;
            logic_op = 1'b1;
         end
         xlsu_pkg::OP_SAR: begin
            r        = 32'($signed(d_ext) >>> cnt) & mask;
            wb       = 1'b1;
            shift_op = 1'b1;
         end
         xlsu_pkg::OP_SHL: begin
            r        = (d << cnt) & mask;
            wb       = 1'b1;
            shift_op = 1'b1;
         end
         xlsu_pkg::OP_SHR: begin
            r        = d >> cnt;
            wb       = 1'b1;
            shift_op = 1'b1;
         end
         xlsu_pkg::OP_NOT: begin
            r  = ~d & mask;
            wb = 1'b1;
         end
         xlsu_pkg::OP_ROL: begin
            r  = rot_wide[2*xlsu_pkg::DataWidth-1:xlsu_pkg::DataWidth] & mask;
            wb = 1'b1;
         end
         default: begin
            r  = '0;
            wb = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (req.operand_width)
         xlsu_pkg::SIZE_BYTE: msb = r[7];
         xlsu_pkg::SIZE_WORD: msb = r[15];
         default:             msb = r[31];
      endcase
   end

   always_comb begin
      flags_nxt = flags_cur;
      if (logic_op || shift_op) begin
         flags_nxt.zero = (r == '0);
         flags_nxt.sign = msb;
      end
      if (logic_op) begin
         flags_nxt.carry    = 1'b0;
         flags_nxt.overflow = 1'b0;
      end
      if (req.op == xlsu_pkg::OP_ROL && cnt != '0) begin
         flags_nxt.carry = r[0];
         if (cnt == xlsu_pkg::CountWidth'(1)) begin
            flags_nxt.overflow = msb ^ r[0];
         end
      end
   end

   assign res.result     = r;
   assign res.write_back = wb;

endmodule

/* rtl/x86_logic_shift_unit_core.sv */
// channel   direction  tdata fields (lsb first)
// req       in         op[3:0] dest_value[35:4] src_value[67:36]
//                      operand_width[69:68] source_width[71:70]
// rsp       out        result[31:0] write_back[32] zero_out[33] sign_out[34]
//                      carry_out[35] overflow_out[36] zero[39:37]
//
// one item per cycle while rsp_tready is high; req passes input, then result register
// the input register and the result register each take part in the handshake
// flags are updated when an item moves from the input register to the result register
// a stalled rsp side holds the result; the input register still takes one more item
// reset is synchronous and clears valids and flags
module x86_logic_shift_unit_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [xlsu_pkg::ReqBits-1:0] req_tdata,  // op, dest_value, src_value,
                                                    // operand_width, source_width
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [xlsu_pkg::RspBits-1:0] rsp_tdata   // result, write_back, zero, sign,
                                                    // carry, overflow
);

   logic                in_valid_ff;
   logic                in_valid_in;
   xlsu_pkg::req_type   in_data_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   xlsu_pkg::res_type   out_data_ff;
   xlsu_pkg::flags_type flags_ff;
   xlsu_pkg::flags_type flags_in;
   xlsu_pkg::res_type   exec_res;
   logic                out_free;
   logic                advance;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   xlsu_exec u_exec (
      .req       (in_data_ff),
      .flags_cur (flags_ff),
      .res       (exec_res),
      .flags_nxt (flags_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= exec_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, flags_ff.overflow, flags_ff.carry, flags_ff.sign,
                        flags_ff.zero, out_data_ff.write_back, out_data_ff.result};

   a_flags_match : assert property (@(posedge clock) disable iff (reset)
      advance |=> (flags_ff == $past(flags_in)))
      else $error("flags not taken from the executed item");

   a_ready_stall : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input blocked without a stalled result");

   a_flags_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(flags_ff))
      else $error("flags changed without an item");

   a_reset_clear : assert property (@(posedge clock)
      reset |=> (flags_ff == '0 && !in_valid_ff && !out_valid_ff))
      else $error("state not cleared by reset");

endmodule
